>>> rtl/smes_pkg.sv
// shared types and constants of the sparse matrix entry store
// depends on nothing; the interfaces, the engine, the top and the testbench import it
package smes_pkg;

	// fixed field widths of the request and result beats
	localparam int OP_W    = 2;
	localparam int COORD_W = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 9;

	// operation codes; the fourth code is a no-op
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic                      found;
		logic                      status;
		logic [COUNT_W-1:0]        entry_count;
	} rsp_t;

endpackage

>>> rtl/smes_req_if.sv
// request channel of the sparse matrix entry store: valid/ready plus payload
// depends on smes_pkg
interface smes_req_if;
	import smes_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic [COORD_W-1:0]        row;
	logic [COORD_W-1:0]        col;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output op, output row, output col, output value,
		input ready);
	modport sink (input valid, input op, input row, input col, input value,
		output ready);

endinterface

>>> rtl/smes_rsp_if.sv
// result channel of the sparse matrix entry store: valid/ready plus payload
// depends on smes_pkg
interface smes_rsp_if;
	import smes_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic                      found;
	logic                      status;
	logic [COUNT_W-1:0]        entry_count;

	modport source (output valid, output read_value, output found, output status,
		output entry_count, input ready);
	modport sink (input valid, input read_value, input found, input status,
		input entry_count, output ready);

endinterface

>>> rtl/smes_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module smes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/smes_engine.sv
// search and update engine: linear scan of the entry ram, then at most one write-back
// depends on smes_pkg and smes_ram
module smes_engine #(
	parameter int CAPACITY   = 256,
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  smes_pkg::req_t in_req,
	output logic          res_valid,
	input  logic          res_take,
	output smes_pkg::rsp_t res
);
	import smes_pkg::*;

	localparam int KEY_W  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WORD_W = 1 + 2 * KEY_W + VALUE_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	typedef struct packed {
		logic               vld;
		logic [KEY_W-1:0]   row;
		logic [KEY_W-1:0]   col;
		logic [VALUE_W-1:0] value;
	} word_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               issue_done_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  idx_s1;
	logic               hit_q;
	logic [ADDR_W-1:0]  hit_idx_q;
	logic [VALUE_W-1:0] hit_val_q;
	logic               free_q;
	logic [ADDR_W-1:0]  free_idx_q;
	logic [CNT_W-1:0]   cnt_q;
	rsp_t               res_q;

	logic [OP_W-1:0]    op_q;
	logic [KEY_W-1:0]   row_q;
	logic [KEY_W-1:0]   col_q;
	logic [VALUE_W-1:0] value_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	word_t              ram_wdata;
	logic               ram_re;
	word_t              ram_rdata;

	logic               entry_hit;
	logic               entry_free;
	logic               last_cmp;
	logic               wr_act;
	logic               wr_new;
	logic               wr_over;
	logic               rm;
	logic               full_drop;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	smes_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// compare of the slot returned by the ram
	always_comb begin
		ram_re     = (state_q == ST_SCAN) && !issue_done_q;
		entry_hit  = pend_s1 && ram_rdata.vld && (ram_rdata.row == row_q)
			&& (ram_rdata.col == col_q);
		entry_free = pend_s1 && !ram_rdata.vld;
		last_cmp   = pend_s1 && (idx_s1 == LAST_ADDR);
	end

	// write-back decision once the scan is over
	always_comb begin
		wr_act    = (op_q == OP_WRITE) && (value_q != '0);
		wr_over   = wr_act && hit_q;
		wr_new    = wr_act && !hit_q && free_q;
		full_drop = wr_act && !hit_q && !free_q;
		rm        = (op_q == OP_REMOVE) && hit_q;

		if (wr_new) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (rm) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
		cnt_ext = {{COUNT_W{1'b0}}, cnt_next};

		ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && (wr_new || wr_over || rm));
		ram_waddr = (state_q == ST_CLEAR) ? addr_q : (wr_new ? free_idx_q : hit_idx_q);
		if (state_q == ST_CLEAR) begin
			ram_wdata = '0;
		end else begin
			ram_wdata.vld   = !rm;
			ram_wdata.row   = row_q;
			ram_wdata.col   = col_q;
			ram_wdata.value = value_q;
		end
	end

	// request payload, captured on the accepted beat, plus the scan captures and the result fields
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= in_req.op;
			row_q   <= in_req.row[KEY_W-1:0];
			col_q   <= in_req.col[KEY_W-1:0];
			value_q <= in_req.value;
		end
		idx_s1 <= addr_q;
		if (entry_hit) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= ram_rdata.value;
		end
		if (entry_free && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == ST_UPDATE) begin
			res_q.read_value  <= ((op_q == OP_READ) && hit_q) ? hit_val_q : '0;
			res_q.found       <= hit_q;
			res_q.status      <= full_drop;
			res_q.entry_count <= cnt_ext[COUNT_W-1:0];
		end
	end

	// sequencer: clearing pass, scan, write-back, hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			pend_s1      <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			cnt_q        <= '0;
		end else begin
			pend_s1 <= ram_re;
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						addr_q       <= '0;
						issue_done_q <= 1'b0;
						hit_q        <= 1'b0;
						free_q       <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						addr_q <= addr_q + ADDR_W'(1);
						if (addr_q == LAST_ADDR) begin
							issue_done_q <= 1'b1;
						end
					end
					if (entry_hit) begin
						hit_q <= 1'b1;
					end
					if (entry_free) begin
						free_q <= 1'b1;
					end
					if (last_cmp) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cnt_q   <= cnt_next;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

>>> rtl/sparse_matrix_entry_store.sv
// sparse matrix entry store: each request scans all CAPACITY slots of one ram.
// the ram read port gives one slot per cycle, and a new request is taken only after
// the engine has handed off the result of the last one.
// a result register lets the next request in while a beat waits.
// after reset a clearing pass empties every slot before the first request.
module sparse_matrix_entry_store #(
	parameter int CAPACITY   = 256,
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	smes_req_if.sink      req,
	smes_rsp_if.source    rsp
);
	import smes_pkg::*;

	req_t in_req;
	logic in_ready;
	logic res_valid;
	logic res_take;
	rsp_t res;
	logic out_valid_q;
	rsp_t out_q;

	// request beat into the engine
	always_comb begin
		in_req.op    = req.op;
		in_req.row   = req.row;
		in_req.col   = req.col;
		in_req.value = req.value;
	end
	assign req.ready = in_ready;

	smes_engine #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// result register in front of the output channel
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_q.read_value;
	assign rsp.found       = out_q.found;
	assign rsp.status      = out_q.status;
	assign rsp.entry_count = out_q.entry_count;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the sparse matrix entry store: a table predictor
// checks every result beat; depends on smes_pkg, smes_req_if, smes_rsp_if and
// sparse_matrix_entry_store

// predicted table contents and the queue of result beats still to come
class entry_scoreboard #(int DEPTH = 256, int KEY_BITS = 16);
	logic [smes_pkg::COORD_W-1:0]        slot_row[DEPTH];
	logic [smes_pkg::COORD_W-1:0]        slot_col[DEPTH];
	logic signed [smes_pkg::VALUE_W-1:0] slot_value[DEPTH];
	bit                                  slot_used[DEPTH];
	int                                  stored;
	smes_pkg::rsp_t                      due_results[$];
	int                                  errors;

	function logic [smes_pkg::COORD_W-1:0] key_bits(logic [smes_pkg::COORD_W-1:0] x);
		return x & smes_pkg::COORD_W'((64'd1 << KEY_BITS) - 1);
	endfunction

	function int locate(logic [smes_pkg::COORD_W-1:0] r, logic [smes_pkg::COORD_W-1:0] c);
		for (int i = 0; i < DEPTH; i++)
			if (slot_used[i] && slot_row[i] == r && slot_col[i] == c)
				return i;
		return -1;
	endfunction

	function int first_free();
		for (int i = 0; i < DEPTH; i++)
			if (!slot_used[i])
				return i;
		return -1;
	endfunction

	function bit full();
		return stored == DEPTH;
	endfunction

	function int outstanding();
		return due_results.size();
	endfunction

	// any stored key, starting the search at a random slot
	function bit pick_stored(output logic [smes_pkg::COORD_W-1:0] r,
			output logic [smes_pkg::COORD_W-1:0] c);
		int start;
		int idx;
		start = $urandom_range(DEPTH - 1);
		r = '0;
		c = '0;
		for (int k = 0; k < DEPTH; k++) begin
			idx = (start + k) % DEPTH;
			if (slot_used[idx]) begin
				r = slot_row[idx];
				c = slot_col[idx];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// apply one accepted request beat to the table and queue its result
	function void note_request(smes_pkg::req_t item);
		smes_pkg::rsp_t want;
		logic [smes_pkg::COORD_W-1:0] r;
		logic [smes_pkg::COORD_W-1:0] c;
		int hit;
		int spot;
		r = key_bits(item.row);
		c = key_bits(item.col);
		hit = locate(r, c);
		want = '0;
		want.found = (hit >= 0);
		case (item.op)
			smes_pkg::OP_WRITE: begin
				// a zero value never creates or changes an entry
				if (item.value != 0) begin
					if (hit >= 0) begin
						slot_value[hit] = item.value;
					end else begin
						spot = first_free();
						if (spot < 0) begin
							want.status = 1'b1;
						end else begin
							slot_row[spot] = r;
							slot_col[spot] = c;
							slot_value[spot] = item.value;
							slot_used[spot] = 1'b1;
							stored++;
						end
					end
				end
			end
			smes_pkg::OP_READ: begin
				if (hit >= 0)
					want.read_value = slot_value[hit];
			end
			smes_pkg::OP_REMOVE: begin
				if (hit >= 0) begin
					slot_used[hit] = 1'b0;
					stored--;
				end
			end
			default: ;
		endcase
		want.entry_count = smes_pkg::COUNT_W'(stored);
		due_results.push_back(want);
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	// compare one result beat with the oldest prediction
	function void check_result(smes_pkg::rsp_t got);
		smes_pkg::rsp_t want;
		if (due_results.size() == 0) begin
			flag($sformatf("unexpected result beat: read_value %0d found %0b status %0b count %0d",
				got.read_value, got.found, got.status, got.entry_count));
			return;
		end
		want = due_results.pop_front();
		if (got.read_value !== want.read_value || got.found !== want.found ||
				got.status !== want.status || got.entry_count !== want.entry_count)
			flag($sformatf("mismatch: want value %0d found %0b status %0b count %0d, got %0d %0b %0b %0d",
				want.read_value, want.found, want.status, want.entry_count,
				got.read_value, got.found, got.status, got.entry_count));
	endfunction
endclass

module testbench;
	import smes_pkg::*;

	localparam int CAPACITY     = 256;
	localparam int COORD_BITS   = 16;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int IDLE_PCT     = 34;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 1500;
	localparam int STALL_LIMIT  = 6000;
	localparam int DRAIN_CYCLES = CAPACITY + 16;
	localparam int POOL_SIZE    = 20;

	// unassigned op code, passes through as a no-op
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady;
	int   results_seen;
	int   stall_cycles;

	logic [COORD_W-1:0] pool_row[POOL_SIZE];
	logic [COORD_W-1:0] pool_col[POOL_SIZE];

	entry_scoreboard #(.DEPTH(CAPACITY), .KEY_BITS(COORD_BITS)) sb = new;

	smes_req_if req ();
	smes_rsp_if rsp ();

	sparse_matrix_entry_store #(
		.CAPACITY(CAPACITY),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// beat monitor, prediction and stall watchdog
	always @(posedge clk) begin : beat_monitor
		rsp_t got;
		req_t taken;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got.read_value = rsp.read_value;
				got.found = rsp.found;
				got.status = rsp.status;
				got.entry_count = rsp.entry_count;
				sb.check_result(got);
				results_seen++;
			end
			if (req.valid && req.ready) begin
				taken.op = req.op;
				taken.row = req.row;
				taken.col = req.col;
				taken.value = req.value;
				sb.note_request(taken);
			end
			if ((rsp.valid && rsp.ready) || (req.valid && req.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// result side: random ready, one long hold-off to back the block up
	initial begin : result_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// offer one request beat after a random gap (none while steady), hold it until taken
	task automatic send_request(logic [OP_W-1:0] op, logic [COORD_W-1:0] row,
			logic [COORD_W-1:0] col, logic signed [VALUE_W-1:0] value);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.row <= row;
		req.col <= col;
		req.value <= value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	function automatic void fresh_key(output logic [COORD_W-1:0] r,
			output logic [COORD_W-1:0] c);
		r = COORD_W'($urandom);
		c = COORD_W'($urandom);
	endfunction

	function automatic void pool_key(output logic [COORD_W-1:0] r,
			output logic [COORD_W-1:0] c);
		int i;
		i = $urandom_range(POOL_SIZE - 1);
		r = pool_row[i];
		c = pool_col[i];
	endfunction

	function automatic void stored_key(output logic [COORD_W-1:0] r,
			output logic [COORD_W-1:0] c);
		if (!sb.pick_stored(r, c))
			fresh_key(r, c);
	endfunction

	// mostly random values, with zero and the extremes now and then
	function automatic logic signed [VALUE_W-1:0] any_value();
		case ($urandom_range(19))
			0: return '0;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit does_work(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value);
		return op != OP_NOP && !(op == OP_WRITE && value == 0);
	endfunction

	initial begin : stimulus
		logic [OP_W-1:0]           op;
		logic [COORD_W-1:0]        r;
		logic [COORD_W-1:0]        c;
		logic signed [VALUE_W-1:0] v;
		int sel;
		int done;
		int tail;
		int j;

		req.valid <= 1'b0;
		req.op <= OP_NOP;
		req.row <= '0;
		req.col <= '0;
		req.value <= '0;
		steady = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, zero write, overwrite, no-op, removes
		send_request(OP_READ,   16'h0000, 16'h0000, 32'h0000_0000);
		send_request(OP_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000);
		send_request(OP_WRITE,  16'h0000, 16'h0000, 32'h7fff_ffff);
		send_request(OP_WRITE,  16'hffff, 16'hffff, 32'h8000_0000);
		send_request(OP_WRITE,  16'hffff, 16'h0000, 32'hffff_ffff);
		send_request(OP_WRITE,  16'h0000, 16'hffff, 32'h0000_0001);
		send_request(OP_READ,   16'h0000, 16'h0000, 32'hffff_ffff);
		send_request(OP_READ,   16'hffff, 16'hffff, 32'h0000_0000);
		send_request(OP_WRITE,  16'h0000, 16'h0000, 32'h0000_0000);
		send_request(OP_READ,   16'h0000, 16'h0000, 32'h0000_0000);
		send_request(OP_WRITE,  16'h0000, 16'h0000, 32'h1234_5678);
		send_request(OP_READ,   16'h0000, 16'h0000, 32'h0000_0000);
		send_request(OP_NOP,    16'hffff, 16'h0000, 32'hdead_beef);
		send_request(OP_NOP,    16'h1357, 16'h2468, 32'h0000_0000);
		send_request(OP_WRITE,  16'h1234, 16'h5678, 32'h0000_0000);
		send_request(OP_REMOVE, 16'hffff, 16'h0000, 32'h0000_0000);
		send_request(OP_READ,   16'hffff, 16'h0000, 32'h0000_0000);
		send_request(OP_REMOVE, 16'hffff, 16'h0000, 32'h0000_0000);
		send_request(OP_WRITE,  16'haaaa, 16'h5555, 32'ha5a5_a5a5);
		send_request(OP_READ,   16'h5555, 16'haaaa, 32'h0000_0000);
		send_request(OP_READ,   16'haaaa, 16'h5555, 32'h5a5a_5a5a);
		send_request(OP_READ,   16'hffff, 16'hffff, 32'h0000_0000);

		// key pool, some keys sharing a row or a column with others
		for (int i = 0; i < POOL_SIZE; i++) begin
			fresh_key(pool_row[i], pool_col[i]);
			if (i >= 8) begin
				j = $urandom_range(i - 1);
				if ($urandom_range(1))
					pool_row[i] = pool_row[j];
				else
					pool_col[i] = pool_col[j];
			end
		end

		// mixed traffic on a small key set
		done = 0;
		while (done < 200) begin
			sel = $urandom_range(99);
			v = any_value();
			if (sel < 40) begin
				op = OP_WRITE;
				if ($urandom_range(99) < 85) pool_key(r, c);
				else fresh_key(r, c);
			end else if (sel < 65) begin
				op = OP_READ;
				if ($urandom_range(1)) pool_key(r, c);
				else stored_key(r, c);
			end else if (sel < 85) begin
				op = OP_REMOVE;
				if ($urandom_range(1)) pool_key(r, c);
				else stored_key(r, c);
			end else if (sel < 92) begin
				op = OP_READ;
				fresh_key(r, c);
			end else if (sel < 96) begin
				op = OP_NOP;
				pool_key(r, c);
			end else begin
				op = OP_REMOVE;
				fresh_key(r, c);
			end
			send_request(op, r, c, v);
			if (does_work(op, v))
				done++;
		end

		// fill the table, then keep writing new keys into a full table
		done = 0;
		tail = 0;
		while (tail < 70 && done < 600) begin
			steady = (done < 120);
			sel = $urandom_range(99);
			v = any_value();
			if (sel < 75) begin
				op = OP_WRITE;
				fresh_key(r, c);
			end else if (sel < 85) begin
				op = OP_WRITE;
				stored_key(r, c);
			end else if (sel < 90) begin
				op = OP_READ;
				stored_key(r, c);
			end else if (sel < 95) begin
				op = OP_REMOVE;
				stored_key(r, c);
			end else begin
				op = OP_WRITE;
				pool_key(r, c);
			end
			send_request(op, r, c, v);
			if (does_work(op, v)) begin
				done++;
				if (sb.full())
					tail++;
			end
		end
		steady = 1'b0;

		// drain: mostly removes of stored keys
		done = 0;
		while (done < 150) begin
			sel = $urandom_range(99);
			v = any_value();
			if (sel < 55) begin
				op = OP_REMOVE;
				stored_key(r, c);
			end else if (sel < 75) begin
				op = OP_READ;
				stored_key(r, c);
			end else if (sel < 85) begin
				op = OP_REMOVE;
				fresh_key(r, c);
			end else if (sel < 95) begin
				op = OP_WRITE;
				fresh_key(r, c);
			end else begin
				op = OP_NOP;
				stored_key(r, c);
			end
			send_request(op, r, c, v);
			if (does_work(op, v))
				done++;
		end

		// wait out every result, then watch for stray beats
		req.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/smes_pkg.sv
rtl/smes_req_if.sv
rtl/smes_rsp_if.sv
rtl/smes_ram.sv
rtl/smes_engine.sv
rtl/sparse_matrix_entry_store.sv
tb/sv/testbench.sv
